>>> src/lms_system_identifier_top_assert.svh
// ---------------------------------------------------------------------------
// LMS system identifier assertion macros
// Concurrent checks sampled on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LMS_SYSTEM_IDENTIFIER_TOP_ASSERT_SVH
`define LMS_SYSTEM_IDENTIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMS_SI_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMS_SI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/lms_si_pkg.sv
// ---------------------------------------------------------------------------
// LMS system identifier package
// Shared widths, register indexes, the tap payload and control types.
// ---------------------------------------------------------------------------
`default_nettype none

package lms_si_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WEIGHT_W   = 24;
  localparam int STEP_W     = 15;
  localparam int SE_W       = 32;
  localparam int PROD_W     = SE_W + SAMPLE_W;
  localparam int MAC_PROD_W = WEIGHT_W + SAMPLE_W;
  localparam int UPD_SHIFT  = 25;
  localparam int OUT_SHIFT  = 20;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FROZEN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_STEP   = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd164;

  // One tap of the adaptive filter: its weight and the noise sample it pairs with.
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] w;
    logic signed [SAMPLE_W-1:0] h;
  } tap_t;

  // Control shared by the cell chain and the arithmetic unit.
  typedef struct packed {
    logic rotate;
    logic update;
    logic hist_shift;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_OUT_Y,
    ST_ERR,
    ST_STEP,
    ST_UPD,
    ST_FINISH
  } lms_state_t;

endpackage

`default_nettype wire

>>> src/lms_si_cell.sv
// ---------------------------------------------------------------------------
// LMS identifier tap cell
// Holds one weight and one noise sample; rotates with the ring or shifts the
// noise delay line by one position.
// ---------------------------------------------------------------------------
`default_nettype none

module lms_si_cell (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lms_si_pkg::chain_ctrl_t               ctrl,
  input  wire lms_si_pkg::tap_t                      rot_in,
  input  wire logic signed [lms_si_pkg::SAMPLE_W-1:0] hist_in,
  output lms_si_pkg::tap_t                           tap_q
);
  import lms_si_pkg::*;

  tap_t tap_r;

  // Rotation moves the whole tap; the history shift moves the sample only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (ctrl.rotate) begin
      tap_r <= rot_in;
    end else if (ctrl.hist_shift) begin
      tap_r.h <= hist_in;
    end
  end

  assign tap_q = tap_r;

endmodule

`default_nettype wire

>>> src/lms_si_alu.sv
// ---------------------------------------------------------------------------
// LMS identifier arithmetic unit
// Two pipeline slots in the tap ring: one shared multiplier for the output
// dot product and for the weight update, then the saturating weight add.
// ---------------------------------------------------------------------------
`default_nettype none

module lms_si_alu (
  input  wire logic                                clk,
  input  wire lms_si_pkg::chain_ctrl_t             ctrl,
  input  wire lms_si_pkg::tap_t                    head,
  input  wire logic signed [lms_si_pkg::SE_W-1:0]  se,
  output lms_si_pkg::tap_t                         tail,
  output logic signed [lms_si_pkg::PROD_W-1:0]     prod
);
  import lms_si_pkg::*;

  localparam int D_W   = PROD_W - UPD_SHIFT;
  localparam int SUM_W = WEIGHT_W + 2;

  logic signed [SE_W-1:0]     mult_a;
  logic signed [PROD_W-1:0]   mult_p;
  tap_t                       s1_r;
  logic signed [PROD_W-1:0]   s1_p_r;
  tap_t                       s2_r;
  tap_t                       s2_nxt;
  logic signed [PROD_W-1:0]   p_rnd;
  logic signed [D_W-1:0]      delta;
  logic signed [SUM_W-1:0]    w_sum;

  // Weight for the dot product, step times error for the update.
  assign mult_a = ctrl.update ? se : SE_W'(head.w);
  assign mult_p = mult_a * head.h;

  // Round half up, then saturate the new weight to its 24-bit range.
  always_comb begin
    p_rnd  = s1_p_r + (PROD_W'(1) << (UPD_SHIFT - 1));
    delta  = p_rnd[PROD_W-1:UPD_SHIFT];
    w_sum  = SUM_W'(s1_r.w) + SUM_W'(delta);
    s2_nxt = s1_r;
    if (ctrl.update) begin
      if (&w_sum[SUM_W-1:WEIGHT_W-1] || ~|w_sum[SUM_W-1:WEIGHT_W-1]) begin
        s2_nxt.w = w_sum[WEIGHT_W-1:0];
      end else begin
        s2_nxt.w = w_sum[SUM_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                  : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
    end
  end

  // Both slots advance with the ring.
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      s1_r   <= head;
      s1_p_r <= mult_p;
      s2_r   <= s2_nxt;
    end
  end

  assign tail = s2_r;
  assign prod = s1_p_r;

endmodule

`default_nettype wire

>>> src/lms_system_identifier_top.sv
// ---------------------------------------------------------------------------
// LMS system identifier
// Adaptive FIR path model trained online by LMS from injected noise.
// ---------------------------------------------------------------------------
// Channel  | Dir | Signals                    | Contents
// in_      | in  | tvalid tready tdata[31:0]  | mic_error, aux_noise
// out_     | out | tvalid tready tdata[31:0]  | estimate_error, model_output
//          |     | tuser                      | adapted
// cfg_     | in  | we addr[0] wdata[14:0]     | 0 model_frozen, 1 step_size
//
// An adapting request makes two full turns of the TAPS+2 slot tap ring
// through the single multiplier, one for the output and one for the update,
// with the output, error and step-times-error steps in between, then a
// finish step and a return to idle. A frozen request goes from acceptance
// straight to the finish step. The synchronous reset clears the tap cells,
// configuration, control state and result valid, and no request is taken
// while reset is held. A stalled result holds the block in its last step.
// ---------------------------------------------------------------------------
`default_nettype none

module lms_system_identifier_top #(
  parameter int TAPS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] mic_error, [31:16] aux_noise
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] estimate_error, [31:16] model_output
  output logic             out_tuser,  // [0] adapted
  input  wire logic        cfg_we,
  input  wire logic [lms_si_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lms_si_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lms_si_pkg::*;

  localparam int CNT_W = $clog2(TAPS + 2);
  localparam int ACC_W = MAC_PROD_W + $clog2(TAPS) + 1;
  localparam int Q_W   = ACC_W - OUT_SHIFT;

  // Configuration registers
  logic              frozen_r;
  logic [STEP_W-1:0] step_r;

  // Control
  lms_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  chain_ctrl_t       ctrl;
  logic              acc_en, y_ld, e_ld, se_ld, fin;
  logic              in_acc;

  // Request and arithmetic registers
  logic                        item_frz_r;
  logic signed [SAMPLE_W-1:0]  mic_r;
  logic signed [SAMPLE_W-1:0]  noise_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [SAMPLE_W-1:0]  y_r, y_nxt;
  logic signed [SAMPLE_W-1:0]  e_r, e_nxt;
  logic signed [SE_W-1:0]      se_r;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [Q_W-1:0]       q_val;
  logic signed [SAMPLE_W:0]    diff;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  // Tap ring
  tap_t                       taps [TAPS];
  tap_t                       rot_in [TAPS];
  logic signed [SAMPLE_W-1:0] hist_in [TAPS];
  tap_t                       tail;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r <= 1'b0;
      step_r   <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IDX_FROZEN: frozen_r <= cfg_wdata[0];
        CFG_IDX_STEP:   step_r   <= cfg_wdata[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and step controls
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    ctrl            = '0;
    acc_en          = 1'b0;
    y_ld            = 1'b0;
    e_ld            = 1'b0;
    se_ld           = 1'b0;
    fin             = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = frozen_r ? ST_FINISH : ST_MAC;
        end
      end
      ST_MAC: begin
        ctrl.rotate = 1'b1;
        acc_en      = (cnt_r != '0) && (cnt_r <= CNT_W'(TAPS));
        if (cnt_r == CNT_W'(TAPS + 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT_Y;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT_Y: begin
        y_ld      = 1'b1;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        e_ld      = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        se_ld     = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ctrl.rotate = 1'b1;
        ctrl.update = 1'b1;
        if (cnt_r == CNT_W'(TAPS + 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          fin             = 1'b1;
          ctrl.hist_shift = !item_frz_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Model output: round half up, saturate to Q1.15; then the saturated error.
  always_comb begin
    acc_rnd = acc_r + (ACC_W'(1) << (OUT_SHIFT - 1));
    q_val   = acc_rnd[ACC_W-1:OUT_SHIFT];
    if (&q_val[Q_W-1:SAMPLE_W-1] || ~|q_val[Q_W-1:SAMPLE_W-1]) begin
      y_nxt = q_val[SAMPLE_W-1:0];
    end else begin
      y_nxt = q_val[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    diff = (SAMPLE_W+1)'(mic_r) - (SAMPLE_W+1)'(y_r);
    if (diff[SAMPLE_W] == diff[SAMPLE_W-1]) begin
      e_nxt = diff[SAMPLE_W-1:0];
    end else begin
      e_nxt = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Request capture, accumulator and error path
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_frz_r <= frozen_r;
      mic_r      <= in_tdata[SAMPLE_W-1:0];
      noise_r    <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      acc_r      <= '0;
    end else if (acc_en) begin
      acc_r <= acc_r + {{(ACC_W-MAC_PROD_W){prod[MAC_PROD_W-1]}}, prod[MAC_PROD_W-1:0]};
    end
    if (y_ld) begin
      y_r <= y_nxt;
    end
    if (e_ld) begin
      e_r <= e_nxt;
    end
    if (se_ld) begin
      se_r <= $signed({1'b0, step_r}) * e_r;
    end
  end

  // Result register; a frozen request returns zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data_r <= item_frz_r ? '0 : {y_r, e_r};
      out_user_r <= !item_frz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Cell chain: the ring turns toward cell 0, whose tap feeds the arithmetic
  // unit; the unit's second slot refills the last cell. The noise delay line
  // takes the new sample into cell 1 and wraps its oldest sample into cell 0.
  for (genvar gi = 0; gi < TAPS; gi++) begin : g_cell
    if (gi == TAPS - 1) begin : g_last
      assign rot_in[gi] = tail;
    end else begin : g_mid
      assign rot_in[gi] = taps[gi+1];
    end
    if (gi == 0) begin : g_first
      assign hist_in[gi] = taps[TAPS-1].h;
    end else if (gi == 1) begin : g_newest
      assign hist_in[gi] = noise_r;
    end else begin : g_older
      assign hist_in[gi] = taps[gi-1].h;
    end
    lms_si_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .rot_in  (rot_in[gi]),
      .hist_in (hist_in[gi]),
      .tap_q   (taps[gi])
    );
  end

  lms_si_alu u_alu (
    .clk  (clk),
    .ctrl (ctrl),
    .head (taps[0]),
    .se   (se_r),
    .tail (tail),
    .prod (prod)
  );

  // Checks
`include "lms_system_identifier_top_assert.svh"

  `LMS_SI_ASSERT_NEXT(a_adapt_starts_mac, in_acc && !frozen_r, state_r == ST_MAC, "adapting request did not start the dot product")
  `LMS_SI_ASSERT_NEXT(a_mac_turn_length, state_r == ST_MAC && cnt_r == CNT_W'(TAPS + 1), state_r == ST_OUT_Y, "dot product pass did not end after a full ring turn")
  `LMS_SI_ASSERT_NEXT(a_finish_waits, state_r == ST_FINISH && out_valid_r && !out_tready, state_r == ST_FINISH, "result overwritten while stalled")
  `LMS_SI_ASSERT_SAME(a_frozen_zero, out_tvalid && !out_tuser, out_tdata == '0, "frozen result carries nonzero data")

endmodule

`default_nettype wire
